/* rtl/core/ple_pkg.sv */
package ple_pkg;

  // default sizes
  localparam int CAPACITY_DEF      = 64;
  localparam int ELEMENT_WIDTH_DEF = 32;

  // fixed port widths
  localparam int OP_W    = 4;
  localparam int POS_W   = 8;
  localparam int VAL_W   = 32;
  localparam int FILL_W  = 7;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT  = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK   = 4'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT   = 4'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK    = 4'd3;
  localparam logic [OP_W-1:0] OP_INSERT_AFTER = 4'd4;
  localparam logic [OP_W-1:0] OP_ERASE       = 4'd5;
  localparam logic [OP_W-1:0] OP_CLEAR       = 4'd6;
  localparam logic [OP_W-1:0] OP_SORT        = 4'd7;
  localparam logic [OP_W-1:0] OP_FILL        = 4'd8;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // what every cell does in a cycle
  typedef enum logic [2:0] {
    CM_HOLD,
    CM_INSERT,
    CM_REMOVE,
    CM_FILL,
    CM_SORT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       odd;
  } cell_ctrl_t;

endpackage

/* rtl/core/ple_cell.sv */
module ple_cell import ple_pkg::*; #(
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
  parameter int IDX_W         = 6,
  parameter int CNT_W         = 7,
  parameter int INDEX         = 0
) (
  input  logic                            clk,
  input  cell_ctrl_t                      ctrl,
  input  logic        [IDX_W-1:0]         edit_idx,
  input  logic        [CNT_W-1:0]         count,
  input  logic signed [ELEMENT_WIDTH-1:0] value,
  input  logic signed [ELEMENT_WIDTH-1:0] left,
  input  logic signed [ELEMENT_WIDTH-1:0] right,
  output logic signed [ELEMENT_WIDTH-1:0] data
);

  localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_CNT  = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] NXT_CNT = CNT_W'(INDEX + 1);
  localparam logic             MY_ODD  = 1'(INDEX % 2);

  logic signed [ELEMENT_WIDTH-1:0] data_next;
  logic                            is_lower;

  // lower member of the compare pair in this sort phase
  assign is_lower = (MY_ODD == ctrl.odd);

  // element update from the broadcast command and the neighbors
  always_comb begin
    data_next = data;
    case (ctrl.mode)
      CM_INSERT: begin
        if (MY_IDX > edit_idx) begin
          data_next = left;
        end else if (MY_IDX == edit_idx) begin
          data_next = value;
        end
      end
      CM_REMOVE: begin
        if (MY_IDX >= edit_idx) begin
          data_next = right;
        end
      end
      CM_FILL: begin
        data_next = ELEMENT_WIDTH'(INDEX);
      end
      CM_SORT: begin
        if (is_lower) begin
          if (NXT_CNT < count && right < data) begin
            data_next = right;
          end
        end else begin
          if (MY_CNT < count && data < left) begin
            data_next = left;
          end
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* rtl/core/positional_list_engine_core.sv */
// channel  | ports                                          | handshake
// ---------+------------------------------------------------+---------------------------
// input    | operation, position, value, fill_count         | start high, busy low
// result   | status, element_count, is_empty, front_value,  | done high for one cycle
//          | back_value                                     |
//
// A row of CAPACITY cells holds the list, one element per cell; every insert or
// erase shifts all cells past the edit point at once, toward or away from it.
// Most words go straight to the report state, where the result register loads,
// and done is registered as it ends; the next word can be accepted at the edge
// that ends done. Sort first runs odd-even transposition over the cell row, one
// phase per cycle, count phases. Busy stays high until the result register loads.
// Reset (rst, synchronous) empties the list; cell contents are not cleared.
// The receiver cannot stall: a result is shown for one cycle only.
module positional_list_engine_core import ple_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic        [OP_W-1:0]    operation,
  input  logic        [POS_W-1:0]   position,
  input  logic signed [VAL_W-1:0]   value,
  input  logic        [FILL_W-1:0]  fill_count,
  output logic                      done,
  output logic        [STAT_W-1:0]  status,
  output logic        [COUNT_W-1:0] element_count,
  output logic                      is_empty,
  output logic signed [VAL_W-1:0]   front_value,
  output logic signed [VAL_W-1:0]   back_value
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SORT,
    S_REPORT
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic        [CNT_W-1:0]         count;
  logic        [CNT_W-1:0]         count_next;
  logic        [CNT_W-1:0]         phase;
  logic        [CNT_W-1:0]         phase_next;
  logic        [STAT_W-1:0]        stat;
  logic        [STAT_W-1:0]        stat_next;
  cell_ctrl_t                      ctrl;
  logic        [IDX_W-1:0]         edit_idx;
  logic        [CNT_W-1:0]         clamp_pos;
  logic        [CNT_W-1:0]         fill_sat;
  logic                            full;
  logic                            empty;
  logic signed [ELEMENT_WIDTH-1:0] elem_in;
  logic signed [ELEMENT_WIDTH-1:0] cell_data [CAPACITY];
  logic        [IDX_W-1:0]         back_idx;

  assign busy     = (state != S_IDLE);
  assign full     = (count == CAP_CNT);
  assign empty    = (count == '0);
  assign elem_in  = ELEMENT_WIDTH'(value);
  assign back_idx = IDX_W'(count - 1'b1);

  // position past the end clamps to the last element
  assign clamp_pos = (CMP_W'(position) >= CMP_W'(count)) ? (count - 1'b1)
                                                        : CNT_W'(position);

  // fill count saturates at capacity
  assign fill_sat = (CMP_W'(fill_count) > CMP_W'(CAPACITY)) ? CAP_CNT
                                                           : CNT_W'(fill_count);

  // command decode and sort sequencing
  always_comb begin
    state_next = state;
    count_next = count;
    phase_next = phase;
    stat_next  = stat;
    ctrl.mode  = CM_HOLD;
    ctrl.odd   = phase[0];
    edit_idx   = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_REPORT;
          stat_next  = ST_DONE;
          case (operation)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AFTER: begin
              if (full) begin
                stat_next = ST_FULL;
              end else begin
                ctrl.mode  = CM_INSERT;
                count_next = count + 1'b1;
                if (operation == OP_PUSH_FRONT || empty) begin
                  edit_idx = '0;
                end else if (operation == OP_PUSH_BACK) begin
                  edit_idx = IDX_W'(count);
                end else begin
                  edit_idx = IDX_W'(clamp_pos + 1'b1);
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_ERASE: begin
              if (empty) begin
                stat_next = ST_EMPTY;
              end else begin
                count_next = count - 1'b1;
                if (operation == OP_POP_FRONT) begin
                  ctrl.mode = CM_REMOVE;
                  edit_idx  = '0;
                end else if (operation == OP_ERASE) begin
                  ctrl.mode = CM_REMOVE;
                  edit_idx  = IDX_W'(clamp_pos);
                end
              end
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            OP_SORT: begin
              phase_next = '0;
              if (count > CNT_W'(1)) begin
                state_next = S_SORT;
              end
            end
            OP_FILL: begin
              ctrl.mode  = CM_FILL;
              count_next = fill_sat;
            end
            default: begin
              stat_next = ST_DONE;
            end
          endcase
        end
      end
      S_SORT: begin
        ctrl.mode  = CM_SORT;
        phase_next = phase + 1'b1;
        if (phase == count - 1'b1) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // row of cells, each linked to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ELEMENT_WIDTH-1:0] left_d;
    logic signed [ELEMENT_WIDTH-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = cell_data[i];
    end else begin : g_left
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_right
      assign right_d = cell_data[i+1];
    end
    ple_cell #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .IDX_W         (IDX_W),
      .CNT_W         (CNT_W),
      .INDEX         (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .edit_idx (edit_idx),
      .count    (count),
      .value    (elem_in),
      .left     (left_d),
      .right    (right_d),
      .data     (cell_data[i])
    );
  end

  // state and registered result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      phase <= '0;
      stat  <= ST_DONE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      phase <= phase_next;
      stat  <= stat_next;
      done  <= (state == S_REPORT);
      if (state == S_REPORT) begin
        status        <= stat;
        element_count <= COUNT_W'(count);
        is_empty      <= empty;
        front_value   <= empty ? '0 : VAL_W'(cell_data[0]);
        back_value    <= empty ? '0 : VAL_W'(cell_data[back_idx]);
      end
    end
  end

  // a result only follows the report cycle
  a_done_after_report: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_REPORT))
    else $error("result strobe without report cycle");

  // occupancy never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("occupancy beyond capacity");

  // full rejection leaves the list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> element_count == COUNT_W'(CAPACITY))
    else $error("full status with list below capacity");

  // an empty list reports zero ends
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (front_value == '0 && back_value == '0))
    else $error("empty list with nonzero end value");

endmodule
